/* sv/mstt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants for the timeout slot table
// Transfer structs, operation and result codes, and the token that runs
// along the chain of slot cells.
// ----------------------------------------------------------------------------
package mstt_pkg;

    // Default number of slots
    localparam int SLOTS_DEF  = 8;
    localparam int MS_PER_SEC = 1000;

    // Operation codes
    localparam logic [1:0] OP_ARM      = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_CHECK    = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_SUCCESS   = 3'd0;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd1;
    localparam logic [2:0] KIND_RESTART   = 3'd2;
    localparam logic [2:0] KIND_NORESTART = 3'd3;
    localparam logic [2:0] KIND_REJECT    = 3'd4;

    // Command transfer
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  slot;
        logic [15:0] timeout_secs;
        logic        notify;
        logic [31:0] now_secs;
    } in_t;

    // Result transfer
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot_index;
        logic [25:0] restart_ms;
        logic        last;
    } out_t;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        check;
        logic [31:0] now_secs;
        logic        any;
        logic [15:0] min_secs;
    } tok_t;

    // Arm write broadcast to all cells
    typedef struct packed {
        logic        en;
        logic [2:0]  slot;
        logic [15:0] timeout_secs;
        logic        notify;
        logic [31:0] start_secs;
    } wr_t;

    // Complete request broadcast to all cells
    typedef struct packed {
        logic       en;
        logic [2:0] slot;
    } cmp_t;

    // Cell report: a notifying slot was freed
    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } rsp_t;

endpackage

/* sv/multi_slot_timeout_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_timeout_table_unit: table of timeout slots
// Arm, complete and check commands on a row of slot cells; reports
// completions, timeouts and the timer restart value.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Results leave one
// per cycle on result, each marked by done for a single cycle; the receiver
// cannot stall them, and last marks the final result of a command. A
// rejected arm gives its result in the cycle after the command and leaves
// the unit free at once. A complete reports success only for an armed
// slot that wants notification. Arm and check send a token down the chain
// of SLOTS cells, one cell per cycle, and the restart item follows at the
// chain end; for a check, timeouts appear as the token passes their cell.
// Unused opcodes give no result and leave busy low.
// ----------------------------------------------------------------------------
module multi_slot_timeout_table_unit #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mstt_pkg::in_t   cmd,
    output logic            done,
    output mstt_pkg::out_t  result
);

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    mstt_pkg::out_t res_reg, res_next;
    mstt_pkg::tok_t tok0_reg, tok0_next;
    mstt_pkg::cmp_t cmp_reg, cmp_next;
    mstt_pkg::wr_t  wr;

    mstt_pkg::tok_t tok_chain [SLOTS+1];
    mstt_pkg::rsp_t rsp [SLOTS];
    mstt_pkg::rsp_t rsp_all;
    logic [SLOTS-1:0] hit_vec;
    mstt_pkg::tok_t tok_end;

    logic accept, arm_ok, arm_bad;

    // Command decode
    always_comb
    begin
        accept  = start && !busy_reg;
        arm_ok  = (cmd.op == mstt_pkg::OP_ARM) && (cmd.timeout_secs != 16'd0) &&
                  (32'(cmd.slot) < SLOTS);
        arm_bad = (cmd.op == mstt_pkg::OP_ARM) && !arm_ok;
    end

    // Arm write, token launch and complete request
    always_comb
    begin
        wr.en           = accept && arm_ok;
        wr.slot         = cmd.slot;
        wr.timeout_secs = cmd.timeout_secs;
        wr.notify       = cmd.notify;
        wr.start_secs   = cmd.now_secs;

        tok0_next.valid    = accept && (arm_ok || (cmd.op == mstt_pkg::OP_CHECK));
        tok0_next.check    = cmd.op == mstt_pkg::OP_CHECK;
        tok0_next.now_secs = cmd.now_secs;
        tok0_next.any      = 1'b0;
        tok0_next.min_secs = 16'd0;

        cmp_next.en   = accept && (cmd.op == mstt_pkg::OP_COMPLETE);
        cmp_next.slot = cmd.slot;
    end

    // Chain of slot cells
    assign tok_chain[0] = tok0_reg;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        mstt_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .cmp     (cmp_reg),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .rsp     (rsp[i])
        );
        assign hit_vec[i] = rsp[i].hit;
    end

    assign tok_end = tok_chain[SLOTS];

    // At most one cell reports in a cycle
    always_comb
    begin
        rsp_all = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (rsp[i].hit)
            begin
                rsp_all.hit = 1'b1;
                rsp_all.idx = rsp_all.idx | rsp[i].idx;
            end
        end
    end

    // Result selection
    always_comb
    begin
        res_next  = '0;
        done_next = 1'b0;
        if (accept && arm_bad)
        begin
            done_next     = 1'b1;
            res_next.kind = mstt_pkg::KIND_REJECT;
            res_next.last = 1'b1;
        end
        else if (rsp_all.hit)
        begin
            done_next           = 1'b1;
            res_next.kind       = cmp_reg.en ? mstt_pkg::KIND_SUCCESS : mstt_pkg::KIND_TIMEOUT;
            res_next.slot_index = rsp_all.idx;
            res_next.last       = cmp_reg.en;
        end
        else if (tok_end.valid)
        begin
            done_next     = 1'b1;
            res_next.last = 1'b1;
            if (tok_end.any)
            begin
                res_next.kind       = mstt_pkg::KIND_RESTART;
                res_next.restart_ms = 26'(tok_end.min_secs) * 26'(mstt_pkg::MS_PER_SEC);
            end
            else
                res_next.kind = mstt_pkg::KIND_NORESTART;
        end
    end

    // Busy from a complete or scan until its final result
    always_comb
    begin
        if (accept)
            busy_next = cmp_next.en || tok0_next.valid;
        else
            busy_next = busy_reg && !(cmp_reg.en || tok_end.valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            tok0_reg <= '0;
            cmp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            tok0_reg <= tok0_next;
            cmp_reg  <= cmp_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    // Only one cell may free a notifying slot per cycle
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("several cells reported at once");

    // The token leaves the chain only during a busy command
    a_tok_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.valid |-> busy_reg)
        else $error("scan token outside a command");

    // A result that is not last means the command is still running
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !res_reg.last) |-> busy_reg)
        else $error("intermediate result with unit idle");

    // A complete and a scan never overlap
    a_cmp_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_reg.en |-> !tok_end.valid)
        else $error("complete overlaps scan");
`endif

endmodule

/* sv/mstt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_cell: one timeout slot
// Holds the state of one slot, tests it for expiry when a check token
// passes, folds its timeout into the running minimum and hands the token on.
// ----------------------------------------------------------------------------
module mstt_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mstt_pkg::wr_t  wr,
    input  mstt_pkg::cmp_t cmp,
    input  mstt_pkg::tok_t tok_in,
    output mstt_pkg::tok_t tok_out,
    output mstt_pkg::rsp_t rsp
);

    logic        used_reg, used_next;
    logic [15:0] timeout_reg;
    logic [31:0] start_reg;
    logic        notify_reg;
    mstt_pkg::tok_t tok_reg, tok_next;

    logic sel_wr, sel_cmp, expire, keep;

    // Address decode and expiry test
    always_comb
    begin
        sel_wr  = wr.en && (32'(wr.slot) == IDX);
        sel_cmp = cmp.en && (32'(cmp.slot) == IDX);
        expire  = tok_in.valid && tok_in.check && used_reg &&
                  ((tok_in.now_secs - start_reg) >= {16'd0, timeout_reg});
        keep    = used_reg && !expire;
    end

    // Next in-use mark
    always_comb
    begin
        if (sel_wr)
            used_next = 1'b1;
        else if (expire || sel_cmp)
            used_next = 1'b0;
        else
            used_next = used_reg;
    end

    // Running minimum over slots still armed
    always_comb
    begin
        tok_next = tok_in;
        if (keep && (!tok_in.any || (timeout_reg < tok_in.min_secs)))
            tok_next.min_secs = timeout_reg;
        tok_next.any = tok_in.any | keep;
    end

    // Report a freed slot that wants notification
    always_comb
    begin
        rsp.hit = (expire || (sel_cmp && used_reg)) && notify_reg;
        rsp.idx = 3'(IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    // Slot payload, loaded on arm
    always_ff @(posedge clk)
    begin
        if (sel_wr)
        begin
            timeout_reg <= wr.timeout_secs;
            start_reg   <= wr.start_secs;
            notify_reg  <= wr.notify;
        end
    end

    assign tok_out = tok_reg;

endmodule
